### rtl/wdcr_pkg.sv
`default_nettype none
package wdcr_pkg;
	localparam int SAMPLE_W = 16;
	localparam int PIXEL_W  = 8;
	localparam int BIN_W    = 6;
	localparam int WEIGHT_W = 11;
	localparam int PCNT_W   = 17;
	localparam logic [11:0] WEIGHT_NUM = 12'd2047;
	localparam logic [7:0]  PIXEL_MAX  = 8'd255;

	typedef enum logic [0:0] {
		REG_BINS_LOG2 = 1'b0,
		REG_DS_LOG2   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_ACC,
		BK_DRAIN
	} back_state_t;

	// one segment handed from front to back
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W:0]          diff;
	} seg_t;
endpackage
`default_nettype wire

### rtl/waveform_density_column_render.sv
// a sample beat reaches the bins through the queue, the load, the divide steps (one per quotient bit) and the update
// the first pixel beat of a finished column is offered from the output register after the divide and the update
// the back end takes a new segment only once idle again; a column drains one bin per cycle unless the output stalls
// the divider in the back end holds up each segment until its quotient is done; the queue holds two segments
// reset: asynchronous active low; bins_log2 = 6, ds_log2 = 8, all bins zero
`default_nettype none
module waveform_density_column_render #(
	parameter int MAX_BINS  = 64,
	parameter int ACC_WIDTH = 27
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire [2:0]         paddr,
	input  wire [31:0]        pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire signed [15:0] sample,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [7:0]        pixel,
	output logic [5:0]        bin_index,
	output logic              last_in_column
);
	import wdcr_pkg::*;

	logic [2:0] bins_log2_q;
	logic [4:0] ds_log2_q;
	reg_idx_t   ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[2]);

	// register file, word address in paddr[2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_log2_q <= 3'd6;
			ds_log2_q   <= 5'd8;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_BINS_LOG2: bins_log2_q <= pwdata[2:0];
				REG_DS_LOG2:   ds_log2_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_BINS_LOG2: prdata = {29'd0, bins_log2_q};
			REG_DS_LOG2:   prdata = {27'd0, ds_log2_q};
			default:       prdata = '0;
		endcase
	end

	// front end pairs samples into segments
	seg_t fr_seg, q_seg;
	logic fr_valid, fr_ready, q_valid, q_ready;

	wdcr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_sample(sample),
		.seg_valid(fr_valid), .seg_ready(fr_ready), .seg(fr_seg)
	);

	// queue decouples front from back
	wdcr_fifo #(.WIDTH($bits(seg_t))) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fr_valid), .wr_ready(fr_ready), .wr_data(fr_seg),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_seg)
	);

	// back end: weight, bin update, column drain
	wdcr_back #(.MAX_BINS(MAX_BINS), .ACC_WIDTH(ACC_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.seg_valid(q_valid), .seg_ready(q_ready), .seg(q_seg),
		.bins_log2(bins_log2_q), .ds_log2(ds_log2_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel(pixel), .bin_index(bin_index), .last_in_column(last_in_column)
	);
endmodule
`default_nettype wire

### rtl/wdcr_fifo.sv
`default_nettype none
module wdcr_fifo #(
	parameter int WIDTH = 49
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_valid,
	output logic             wr_ready,
	input  wire [WIDTH-1:0]  wr_data,
	output logic             rd_valid,
	input  wire              rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	// two-entry queue
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             wr_en, rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end
endmodule
`default_nettype wire

### rtl/wdcr_front.sv
`default_nettype none
module wdcr_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [15:0]            in_sample,
	output logic                         seg_valid,
	input  wire                          seg_ready,
	output wdcr_pkg::seg_t               seg
);
	import wdcr_pkg::*;

	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       have_q;
	logic                       acc;

	// first sample only primes the previous-sample register
	assign in_ready  = seg_ready || !have_q;
	assign seg_valid = in_valid && have_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		if (in_sample < prev_q) begin
			seg.lo = in_sample;
			seg.hi = prev_q;
		end else begin
			seg.lo = prev_q;
			seg.hi = in_sample;
		end
		seg.diff = 17'({seg.hi[15], seg.hi}) - 17'({seg.lo[15], seg.lo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
		end else if (acc) begin
			prev_q <= in_sample;
			have_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

### rtl/wdcr_back.sv
`default_nettype none
module wdcr_back #(
	parameter int MAX_BINS  = 64,
	parameter int ACC_WIDTH = 27
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    seg_valid,
	output logic                   seg_ready,
	input  wire wdcr_pkg::seg_t    seg,
	input  wire [2:0]              bins_log2,
	input  wire [4:0]              ds_log2,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [7:0]             pixel,
	output logic [5:0]             bin_index,
	output logic                   last_in_column
);
	import wdcr_pkg::*;

	// largest power of two not above MAX_BINS
	localparam int MAXB_LOG2 = $clog2(MAX_BINS + 1) - 1;
	localparam int IDX_W     = MAXB_LOG2;
	localparam int NB        = 1 << MAXB_LOG2;

	back_state_t state_q, state_d;

	logic [ACC_WIDTH-1:0] acc_q [NB];
	seg_t                 seg_q;
	logic [17:0]          rem_q;
	logic [17:0]          den_q;
	logic [11:0]          quo_q;
	logic [3:0]           dstep_q;
	logic [PCNT_W-1:0]    pcnt_q;
	logic [IDX_W:0]       didx_q;
	logic                 obuf_v_q;
	logic [7:0]           obuf_pix_q;
	logic [5:0]           obuf_idx_q;
	logic                 obuf_last_q;

	logic [2:0]  eb;
	logic [4:0]  eds;
	logic [IDX_W:0] nbins;
	logic [16:0] span;
	logic        obuf_free;
	logic        obuf_load;
	logic        drain_last;

	always_comb begin
		eb = bins_log2;
		if (eb < 3'd1) eb = 3'd1;
		if (eb > 3'd6) eb = 3'd6;
		if (eb > 3'(MAXB_LOG2)) eb = 3'(MAXB_LOG2);
		eds = (ds_log2 > 5'd16) ? 5'd16 : ds_log2;
		nbins = (IDX_W+1)'(1) << eb;
		span  = 17'd1 << (5'd16 - {2'b0, eb});
		drain_last = (didx_q + 1'b1 == nbins);
	end

	assign obuf_free = !obuf_v_q || out_ready;
	assign obuf_load = (state_q == BK_DRAIN) && obuf_free;
	assign seg_ready = (state_q == BK_IDLE);
	assign out_valid = obuf_v_q;
	assign pixel = obuf_pix_q;
	assign bin_index = obuf_idx_q;
	assign last_in_column = obuf_last_q;

	// restoring divide of 2047*span by span+diff, one quotient bit a cycle
	logic [28:0] num_full;
	assign num_full = 29'(WEIGHT_NUM) * 29'(span);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (seg_valid) state_d = BK_DIV;
			BK_DIV:   if (dstep_q == 4'd0) state_d = BK_ACC;
			BK_ACC:   if (32'(pcnt_q) + 1 >= (32'd1 << eds)) state_d = BK_DRAIN;
			          else state_d = BK_IDLE;
			BK_DRAIN: if (obuf_load && drain_last) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) obuf_v_q <= 1'b0;
		else if (obuf_load) obuf_v_q <= 1'b1;
		else if (out_ready) obuf_v_q <= 1'b0;
	end

	// numerator shift register feeds its low bits into the remainder from the top, 12-bit quotient
	logic [23:0] numsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q   <= '0;
			didx_q   <= '0;
			dstep_q  <= '0;
			for (int i = 0; i < NB; i++) acc_q[i] <= '0;
		end else begin
			case (state_q)
				BK_IDLE: if (seg_valid) begin
					seg_q   <= seg;
					den_q   <= 18'(span) + 18'(seg.diff);
					rem_q   <= 18'(num_full >> 12);
					numsh_q <= {num_full[11:0], 12'd0};
					quo_q   <= '0;
					dstep_q <= 4'd11;
				end
				BK_DIV: begin
					if ({rem_q, numsh_q[23]} >= {1'b0, den_q}) begin
						rem_q <= 18'({rem_q, numsh_q[23]} - {1'b0, den_q});
						quo_q <= {quo_q[10:0], 1'b1};
					end else begin
						rem_q <= {rem_q[16:0], numsh_q[23]};
						quo_q <= {quo_q[10:0], 1'b0};
					end
					numsh_q <= {numsh_q[22:0], 1'b0};
					dstep_q <= dstep_q - 4'd1;
				end
				BK_ACC: begin
					for (int i = 0; i < NB; i++) begin
						logic signed [17:0] lower, upper;
						logic [ACC_WIDTH:0] sum;
						lower = -18'sd32768 + 18'(i * span);
						upper = lower + 18'(span);
						sum = {1'b0, acc_q[i]} + (ACC_WIDTH+1)'(quo_q);
						if (i < nbins && 18'(seg_q.hi) > lower && upper > 18'(seg_q.lo))
							acc_q[i] <= sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
					end
					pcnt_q <= pcnt_q + 1'b1;
					didx_q <= '0;
				end
				BK_DRAIN: if (obuf_free) begin
					logic [ACC_WIDTH+2:0] v;
					logic [ACC_WIDTH+2:0] sh;
					v  = (ACC_WIDTH+3)'(acc_q[0]) * (ACC_WIDTH+3)'(5);
					sh = v >> eds;
					obuf_pix_q  <= (sh > (ACC_WIDTH+3)'(PIXEL_MAX)) ? PIXEL_MAX : sh[7:0];
					obuf_idx_q  <= 6'(didx_q);
					obuf_last_q <= drain_last;
					// bins move down one place, the whole column clears on the last beat
					for (int i = 0; i < NB - 1; i++)
						acc_q[i] <= drain_last ? '0 : acc_q[i + 1];
					acc_q[NB - 1] <= '0;
					didx_q <= didx_q + 1'b1;
					if (drain_last) pcnt_q <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/wdcr_checker.sv
`default_nettype none
module wdcr_assert (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] pixel,
	input wire [5:0] bin_index,
	input wire       last_in_column
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel))
		else $error("pixel dropped under stall");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_in_column ##1 out_valid |->
		bin_index == $past(bin_index) + 6'd1)
		else $error("bin order broken");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_in_column ##1 out_valid |-> bin_index == 6'd0)
		else $error("column does not restart at bin zero");
endmodule

bind waveform_density_column_render wdcr_assert u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.pixel(pixel), .bin_index(bin_index), .last_in_column(last_in_column)
);
`default_nettype wire
